/* src/size_class_bitmap_allocator_defines.svh */
// Assertion macros for the size class bitmap allocator
`ifndef SIZE_CLASS_BITMAP_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_BITMAP_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SCBA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m: lbl");
`define SCBA_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("%m: lbl");
`else
`define SCBA_ASSERT(lbl, clk, rstn, prop)
`define SCBA_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* src/scba_pkg.sv */
// Shared codes and widths of the size class bitmap allocator
`timescale 1ns / 1ps
package scba_pkg;
  localparam int unsigned ClassW = 4;
  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_BLOCK  = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_e;
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  blk;
    logic [12:0] offset;
  } result_t;
endpackage

/* src/size_class_bitmap_allocator.sv */
// Size class bitmap slab allocator: top level
// Alloc checks the blocks in turn; for each non-full block of the class it reduces the rotating
// start modulo the slot count, then reads bitmap words until a free slot is found or the block is full;
// claiming a new block sweeps its (ITEMS_PER_BLOCK+31)/32 bitmap words.
// One item at a time through the single bitmap RAM port; next item taken on return to idle.
// Reset clears the block table, rotating start and handshake state; the bitmap RAM is not cleared.
`timescale 1ns / 1ps
`include "size_class_bitmap_allocator_defines.svh"
module size_class_bitmap_allocator #(
  parameter int unsigned ITEMS_PER_BLOCK = 8192,
  parameter int unsigned NUM_CLASSES     = 12,
  parameter int unsigned NUM_BLOCKS      = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [0:0]  cmd_i,
  input  logic [15:0] size_bytes_i,
  input  logic [3:0]  block_index_i,
  input  logic [12:0] word_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  out_block_o,
  output logic [12:0] out_offset_o
);
  localparam int unsigned WPB    = (ITEMS_PER_BLOCK + 31) / 32;
  localparam int unsigned WW     = $clog2(WPB);
  localparam int unsigned NW_W   = WW + 1;
  localparam int unsigned SLOT_W = WW + 5;
  localparam int unsigned LIM_W  = SLOT_W + 1;
  localparam int unsigned DEPTH  = NUM_BLOCKS * WPB;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned BLK_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned BC_W   = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned SH_W   = LIM_W + 13;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BLK  = 4'd1;
  localparam logic [3:0] S_MOD  = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_EV   = 4'd4;
  localparam logic [3:0] S_CLR  = 4'd5;
  localparam logic [3:0] S_FRD  = 4'd6;
  localparam logic [3:0] S_FEV  = 4'd7;
  localparam logic [3:0] S_RESP = 4'd8;

  logic [3:0] state_q, state_d;
  logic [NUM_BLOCKS-1:0] valid_q, valid_d, full_q, full_d;
  logic [scba_pkg::ClassW-1:0] class_q [NUM_BLOCKS];
  logic [scba_pkg::ClassW-1:0] class_d [NUM_BLOCKS];
  logic [BC_W-1:0] nused_q, nused_d, b_q, b_d;
  logic [12:0] rs_q, rs_d, r_q, r_d;
  logic [3:0] k_q, k_d;
  logic [scba_pkg::ClassW-1:0] cls_q, cls_d;
  logic [LIM_W-1:0] lim_q, lim_d;
  logic [NW_W-1:0] nw_q, nw_d, cnt_q, cnt_d;
  logic [WW-1:0] w_q, w_d;
  logic [BLK_W-1:0] fblk_q, fblk_d;
  logic [SLOT_W+2:0] fslot_q, fslot_d;
  scba_pkg::result_t res_q, res_d, out_q, out_d;
  logic ov_q, ov_d;

  logic ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [31:0] ram_wdata, ram_rdata;

  scba_ram #(.Width(32), .Depth(DEPTH)) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // request decode
  logic [3:0] in_cls;
  logic [LIM_W-1:0] in_lim;
  always_comb begin
    in_cls = 4'd13;
    for (int c = 12; c >= 0; c--) begin
      if ({16'd0, size_bytes_i} <= (32'd8 << c)) begin
        in_cls = 4'(c);
      end
    end
    in_lim = LIM_W'(ITEMS_PER_BLOCK >> in_cls);
    if (in_lim == '0) begin
      in_lim = LIM_W'(1);
    end
  end

  logic [BLK_W-1:0] b_idx;
  logic [SH_W-1:0] lim_sh;
  logic [NW_W:0] wsum;
  logic [WW-1:0] scan_w;
  logic [LIM_W:0] rem;
  logic [31:0] mask, cand, ones;
  logic found;
  logic [4:0] fbit;
  logic [SLOT_W-1:0] slot_n;
  logic [SLOT_W+12:0] off_ext;
  logic [SLOT_W+2:0] fslot_in;
  logic in_blk_ok;

  assign b_idx  = BLK_W'(b_q);
  assign lim_sh = SH_W'(lim_q) << k_q;
  assign ones   = '1;

  always_comb begin
    wsum = (NW_W + 1)'(r_q >> 5) + (NW_W + 1)'(cnt_q);
    if (wsum >= (NW_W + 1)'(nw_q)) begin
      wsum = wsum - (NW_W + 1)'(nw_q);
    end
    scan_w = WW'(wsum);
    rem = (LIM_W + 1)'(lim_q) - (LIM_W + 1)'({w_q, 5'd0});
    mask = (rem >= (LIM_W + 1)'(32)) ? ones : ~(ones << rem[4:0]);
    if (cnt_q == '0) begin
      mask = mask & (ones << r_q[4:0]);
    end
    if (cnt_q == nw_q) begin
      mask = mask & ~(ones << r_q[4:0]);
    end
    cand  = ~ram_rdata & mask;
    found = |cand;
    fbit  = '0;
    for (int i = 31; i >= 0; i--) begin
      if (cand[i]) begin
        fbit = 5'(i);
      end
    end
    slot_n  = {w_q, fbit};
    off_ext = (SLOT_W + 13)'(slot_n) << cls_q;
    fslot_in = (SLOT_W + 3)'(word_offset_i >> class_q[BLK_W'(block_index_i)]);
    in_blk_ok = ({28'd0, block_index_i} < NUM_BLOCKS) && valid_q[BLK_W'(block_index_i)];
  end

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    full_d  = full_q;
    class_d = class_q;
    nused_d = nused_q;
    b_d     = b_q;
    rs_d    = rs_q;
    r_d     = r_q;
    k_d     = k_q;
    cls_d   = cls_q;
    lim_d   = lim_q;
    nw_d    = nw_q;
    cnt_d   = cnt_q;
    w_d     = w_q;
    fblk_d  = fblk_q;
    fslot_d = fslot_q;
    res_d   = res_q;
    out_d   = out_q;
    ov_d    = ov_q;
    ram_we    = 1'b0;
    ram_addr  = ADDR_W'(int'(b_idx) * WPB + int'(scan_w));
    ram_wdata = '0;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d  = '0;
          cls_d  = in_cls;
          lim_d  = in_lim;
          nw_d   = NW_W'((in_lim + LIM_W'(31)) >> 5);
          b_d    = '0;
          fblk_d = BLK_W'(block_index_i);
          fslot_d = fslot_in;
          if (cmd_i == scba_pkg::CMD_FREE) begin
            if (!in_blk_ok) begin
              res_d.status = scba_pkg::ST_BAD_FREE;
              state_d = S_RESP;
            end else begin
              state_d = S_FRD;
            end
          end else if ({28'd0, in_cls} >= NUM_CLASSES) begin
            res_d.status = scba_pkg::ST_TOO_LARGE;
            state_d = S_RESP;
          end else begin
            state_d = S_BLK;
          end
        end
      end
      S_BLK: begin
        cnt_d = '0;
        if (b_q == BC_W'(NUM_BLOCKS)) begin
          if (nused_q < BC_W'(NUM_BLOCKS)) begin
            b_d = nused_q;
            state_d = S_CLR;
          end else begin
            res_d.status = scba_pkg::ST_NO_BLOCK;
            state_d = S_RESP;
          end
        end else if (valid_q[b_idx] && class_q[b_idx] == cls_q && !full_q[b_idx]) begin
          r_d  = rs_q;
          rs_d = rs_q + 13'd1;
          k_d  = 4'd12;
          state_d = S_MOD;
        end else begin
          b_d = b_q + BC_W'(1);
        end
      end
      S_MOD: begin
        if (SH_W'(r_q) >= lim_sh) begin
          r_d = r_q - 13'(lim_sh);
        end
        if (k_q == '0) begin
          state_d = S_RD;
        end else begin
          k_d = k_q - 4'd1;
        end
      end
      S_RD: begin
        w_d = scan_w;
        state_d = S_EV;
      end
      S_EV: begin
        ram_addr = ADDR_W'(int'(b_idx) * WPB + int'(w_q));
        if (found) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | (32'd1 << fbit);
          res_d.blk    = 4'(b_q);
          res_d.offset = off_ext[12:0];
          state_d = S_RESP;
        end else if (cnt_q == nw_q) begin
          full_d[b_idx] = 1'b1;
          b_d = b_q + BC_W'(1);
          state_d = S_BLK;
        end else begin
          cnt_d = cnt_q + NW_W'(1);
          state_d = S_RD;
        end
      end
      S_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = ADDR_W'(int'(b_idx) * WPB + int'(cnt_q));
        ram_wdata = (cnt_q == '0) ? 32'd1 : 32'd0;
        cnt_d = cnt_q + NW_W'(1);
        if (cnt_q == NW_W'(WPB - 1)) begin
          valid_d[b_idx] = 1'b1;
          full_d[b_idx]  = 1'b0;
          class_d[b_idx] = cls_q;
          nused_d = nused_q + BC_W'(1);
          res_d.blk = 4'(b_q);
          state_d = S_RESP;
        end
      end
      S_FRD: begin
        ram_addr = ADDR_W'(int'(fblk_q) * WPB + int'(fslot_q >> 5));
        if (int'(fslot_q) >= WPB * 32) begin
          full_d[fblk_q] = 1'b0;
          state_d = S_RESP;
        end else begin
          state_d = S_FEV;
        end
      end
      S_FEV: begin
        ram_addr  = ADDR_W'(int'(fblk_q) * WPB + int'(fslot_q >> 5));
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~(32'd1 << fslot_q[4:0]);
        full_d[fblk_q] = 1'b0;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!ov_q || out_ready_i) begin
          out_d = res_q;
          ov_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      full_q  <= '0;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        class_q[i] <= '0;
      end
      nused_q <= '0;
      rs_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      full_q  <= full_d;
      class_q <= class_d;
      nused_q <= nused_d;
      rs_q    <= rs_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q     <= b_d;
    r_q     <= r_d;
    k_q     <= k_d;
    cls_q   <= cls_d;
    lim_q   <= lim_d;
    nw_q    <= nw_d;
    cnt_q   <= cnt_d;
    w_q     <= w_d;
    fblk_q  <= fblk_d;
    fslot_q <= fslot_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = ov_q;
  assign status_o     = out_q.status;
  assign out_block_o  = out_q.blk;
  assign out_offset_o = out_q.offset;

  `SCBA_ASSERT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o |=> state_q != S_IDLE)
  `SCBA_ASSERT(a_found_resp, clk_i, rst_ni, state_q == S_EV && found |=> state_q == S_RESP)
  `SCBA_ASSERT(a_prefix, clk_i, rst_ni, $countones(valid_q) == int'(nused_q))
  `SCBA_NEVER(a_wr_idle, clk_i, rst_ni, ram_we && state_q == S_IDLE)
endmodule

/* src/scba_ram.sv */
// Single port synchronous RAM with registered read
`timescale 1ns / 1ps
module scba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* sim/testbench.sv */
// Testbench of the size class bitmap allocator: directed table, then random traffic
`timescale 1ns / 1ps
module testbench;
  localparam int unsigned NBlk = 16;
  localparam int unsigned NSlot = 8192;
  localparam int unsigned NCls = 12;

  typedef struct {
    scba_pkg::cmd_e    cmd;
    logic [15:0]       size;
    logic [3:0]        blk;
    logic [12:0]       off;
    bit                typed;
    scba_pkg::result_t res;
  } row_t;

  typedef struct {
    logic [3:0]  blk;
    logic [12:0] off;
  } live_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [0:0]  cmd_i = scba_pkg::CMD_ALLOC;
  logic [15:0] size_bytes_i = '0;
  logic [3:0]  block_index_i = '0;
  logic [12:0] word_offset_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [3:0]  out_block_o;
  logic [12:0] out_offset_o;

  size_class_bitmap_allocator dut (.*);

  bit          blk_used [NBlk];
  logic [3:0]  blk_cls [NBlk];
  bit          blk_full [NBlk];
  bit          slot_busy [NBlk][NSlot];
  logic [12:0] rot_start;

  scba_pkg::result_t pending_q [$];
  live_t       live_q [$];
  int          errors = 0;
  int          send_idle = 27;
  int          recv_idle = 64;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic scba_pkg::result_t alloc_next(logic [15:0] size);
    scba_pkg::result_t r;
    int unsigned c, lim, b, i, n, s;
    r = '0;
    c = 0;
    while (c < 13 && int'(size) > (8 << c)) c++;
    if (c >= NCls) begin
      r.status = scba_pkg::ST_TOO_LARGE;
      return r;
    end
    lim = NSlot >> c;
    for (b = 0; b < NBlk; b++) begin
      if (!blk_used[b] || blk_cls[b] != c || blk_full[b]) continue;
      s = rot_start % lim;
      rot_start = rot_start + 13'd1;
      for (i = 0; i < lim; i++) begin
        n = s + i;
        if (n >= lim) n -= lim;
        if (!slot_busy[b][n]) begin
          slot_busy[b][n] = 1'b1;
          r.blk = 4'(b);
          r.offset = 13'(n << c);
          return r;
        end
      end
      blk_full[b] = 1'b1;
    end
    for (b = 0; b < NBlk; b++) begin
      if (!blk_used[b]) begin
        blk_used[b] = 1'b1;
        blk_cls[b] = 4'(c);
        blk_full[b] = 1'b0;
        for (i = 0; i < NSlot; i++) slot_busy[b][i] = 1'b0;
        slot_busy[b][0] = 1'b1;
        r.blk = 4'(b);
        return r;
      end
    end
    r.status = scba_pkg::ST_NO_BLOCK;
    return r;
  endfunction

  function automatic scba_pkg::result_t apply_request(scba_pkg::cmd_e cmd, logic [15:0] size,
                                                      logic [3:0] blk, logic [12:0] off);
    scba_pkg::result_t r;
    r = '0;
    if (cmd == scba_pkg::CMD_ALLOC) return alloc_next(size);
    if (!blk_used[blk]) begin
      r.status = scba_pkg::ST_BAD_FREE;
      return r;
    end
    slot_busy[blk][off >> blk_cls[blk]] = 1'b0;
    blk_full[blk] = 1'b0;
    return r;
  endfunction

  task automatic send(scba_pkg::cmd_e cmd, logic [15:0] size, logic [3:0] blk,
                      logic [12:0] off, bit typed, scba_pkg::result_t res);
    scba_pkg::result_t r;
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    size_bytes_i <= size;
    block_index_i <= blk;
    word_offset_i <= off;
    do @(posedge clk_i); while (!in_ready_o);
    r = apply_request(cmd, size, blk, off);
    pending_q.push_back(typed ? res : r);
    if (cmd == scba_pkg::CMD_ALLOC && r.status == scba_pkg::ST_OK) begin
      live_q.push_back('{r.blk, r.offset});
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    scba_pkg::result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o);
          errors++;
        end
        if (out_block_o !== e.blk) begin
          $error("out_block expected %0d actual %0d", e.blk, out_block_o);
          errors++;
        end
        if (out_offset_o !== e.offset) begin
          $error("out_offset expected %0d actual %0d", e.offset, out_offset_o);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t    rows [$];
    scba_pkg::result_t none;
    live_t   lv;
    int      k, p, w, cls;
    none = '0;
    for (k = 0; k < NBlk; k++) begin
      blk_used[k] = 0;
      blk_cls[k] = 0;
      blk_full[k] = 0;
    end
    rot_start = '0;
    rows = '{
      '{scba_pkg::CMD_ALLOC, 16'd0,     4'd0,  13'd0,    1, '{scba_pkg::ST_OK, 4'd0, 13'd0}},
      '{scba_pkg::CMD_ALLOC, 16'd8,     4'd0,  13'd0,    0, '0},
      '{scba_pkg::CMD_ALLOC, 16'd9,     4'd0,  13'd0,    1, '{scba_pkg::ST_OK, 4'd1, 13'd0}},
      '{scba_pkg::CMD_ALLOC, 16'hFFFF,  4'd0,  13'd0,    1,
        '{scba_pkg::ST_TOO_LARGE, 4'd0, 13'd0}},
      '{scba_pkg::CMD_ALLOC, 16'd16385, 4'd0,  13'd0,    1,
        '{scba_pkg::ST_TOO_LARGE, 4'd0, 13'd0}},
      '{scba_pkg::CMD_ALLOC, 16'd16384, 4'd0,  13'd0,    1, '{scba_pkg::ST_OK, 4'd2, 13'd0}},
      '{scba_pkg::CMD_FREE,  16'hFFFF,  4'd15, 13'h1FFF, 1,
        '{scba_pkg::ST_BAD_FREE, 4'd0, 13'd0}},
      '{scba_pkg::CMD_FREE,  16'd0,     4'd0,  13'd1,    1, '{scba_pkg::ST_OK, 4'd0, 13'd0}},
      '{scba_pkg::CMD_FREE,  16'd0,     4'd0,  13'd1,    1, '{scba_pkg::ST_OK, 4'd0, 13'd0}},
      '{scba_pkg::CMD_FREE,  16'd0,     4'd1,  13'h1FFF, 1, '{scba_pkg::ST_OK, 4'd0, 13'd0}},
      '{scba_pkg::CMD_ALLOC, 16'd16384, 4'd0,  13'd0,    0, '0},
      '{scba_pkg::CMD_ALLOC, 16'd16000, 4'd0,  13'd0,    0, '0},
      '{scba_pkg::CMD_ALLOC, 16'd8192,  4'd0,  13'd0,    0, '0},
      '{scba_pkg::CMD_ALLOC, 16'd4096,  4'd0,  13'd0,    0, '0},
      '{scba_pkg::CMD_ALLOC, 16'd2048,  4'd0,  13'd0,    0, '0},
      '{scba_pkg::CMD_ALLOC, 16'd17,    4'd0,  13'd0,    0, '0},
      '{scba_pkg::CMD_ALLOC, 16'd64,    4'd0,  13'd0,    0, '0},
      '{scba_pkg::CMD_FREE,  16'd0,     4'd2,  13'h1FFF, 0, '0},
      '{scba_pkg::CMD_ALLOC, 16'd12000, 4'd0,  13'd0,    0, '0},
      '{scba_pkg::CMD_ALLOC, 16'd1,     4'd0,  13'd0,    0, '0}
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i])
      send(rows[i].cmd, rows[i].size, rows[i].blk, rows[i].off, rows[i].typed, rows[i].res);
    for (k = 0; k < 360; k++) begin
      if (k == 120) begin
        send_idle = 64;
        recv_idle = 27;
      end
      if (k == 240) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (k == 180) begin
        in_valid_i <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk_i);
      end
      p = $urandom_range(99);
      if (p < 55) begin
        cls = ($urandom_range(9) < 8) ? $urandom_range(5) : $urandom_range(8);
        w = (cls == 0) ? $urandom_range(8) : $urandom_range(8 << cls, (4 << cls) + 1);
        send(scba_pkg::CMD_ALLOC, 16'(w), 4'($urandom), 13'($urandom), 0, none);
      end else if (p < 90 && live_q.size() != 0) begin
        w = $urandom_range(live_q.size() - 1);
        lv = live_q[w];
        live_q.delete(w);
        send(scba_pkg::CMD_FREE, 16'($urandom), lv.blk, lv.off, 0, none);
      end else begin
        send(scba_pkg::cmd_e'($urandom_range(1)), 16'($urandom), 4'($urandom),
             13'($urandom), 0, none);
      end
    end
    for (k = 0; k < 70; k++) begin
      send(scba_pkg::CMD_ALLOC, 16'd16384, 4'($urandom), 13'($urandom), 0, none);
    end
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+src
src/scba_pkg.sv
src/scba_ram.sv
src/size_class_bitmap_allocator.sv
sim/testbench.sv
